// File: design/adaptive_energy_voice_detector_top_macros.svh
// assertion macros for the adaptive energy voice detector
// used by the top level only, no other dependencies
`ifndef ADAPTIVE_ENERGY_VOICE_DETECTOR_TOP_MACROS_SVH
`define ADAPTIVE_ENERGY_VOICE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define AEVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AEVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/aevd_pkg.sv
// shared types and constants of the adaptive energy voice detector
// no dependencies
package aevd_pkg;

  localparam int unsigned MAX_CAL_FRAMES_DEF = 131071;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned LOG_STEPS = 24;
  localparam int unsigned CNT_W = 5;
  localparam logic [27:0] DB_PER_LOG2_Q24 = 28'd101008905;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [16:0] RST_CAL_FRAMES = 17'd50;
  localparam logic [15:0] RST_INIT_FLOOR = 16'd328;
  localparam logic [15:0] RST_MIN_FLOOR = 16'd33;
  localparam logic [15:0] RST_MAX_FLOOR = 16'd16384;
  localparam logic [16:0] RST_ALPHA = 17'd3277;
  localparam logic [15:0] RST_MIN_SPEECH = 16'd328;
  localparam logic [14:0] RST_ONSET = 15'd1536;
  localparam logic [14:0] RST_SAT = 15'd5120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_FRAMES = 3'd0,
    CFG_INIT_FLOOR = 3'd1,
    CFG_MIN_FLOOR  = 3'd2,
    CFG_MAX_FLOOR  = 3'd3,
    CFG_ALPHA      = 3'd4,
    CFG_MIN_SPEECH = 3'd5,
    CFG_ONSET      = 3'd6,
    CFG_SAT        = 3'd7
  } cfg_idx_e;

  localparam logic OP_ANALYZE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic load;
    logic restart;
    logic cal_acc;
    logic cal_fin;
    logic div_init_cal;
    logic div_init_score;
    logic div_step;
    logic log_init_rms;
    logic log_init_floor;
    logic log_step;
    logic log_save;
    logic mul;
    logic snr;
    logic score_one;
    logic score_fin;
    logic ema1;
    logic ema2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic restart_op;
    logic calibrated;
    logic score_en;
    logic range_pos;
    logic score_zero;
  } status_t;

endpackage

// File: design/aevd_in_if.sv
// input request channel: opcode and frame level
// depends on nothing
interface aevd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] level_rms;

  modport source (output valid, output opcode, output level_rms, input ready);
  modport sink (input valid, input opcode, input level_rms, output ready);
endinterface

// File: design/aevd_out_if.sv
// result request channel: score, snr, floor and calibration flag
// depends on nothing
interface aevd_out_if;
  logic               valid;
  logic               ready;
  logic        [16:0] voice_score;
  logic signed [15:0] snr_db;
  logic        [15:0] noise_floor;
  logic               calibrating;

  modport source (output valid, output voice_score, output snr_db, output noise_floor,
                  output calibrating, input ready);
  modport sink (input valid, input voice_score, input snr_db, input noise_floor,
                input calibrating, output ready);
endinterface

// File: design/aevd_ctrl.sv
// sequencing state machine of the voice detector
// depends on aevd_pkg
module aevd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  aevd_pkg::status_t status_i,
  output aevd_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CAL_INIT, S_CAL_DIV, S_CAL_FIN, S_LOG_R, S_LOG_SAVE, S_LOG_F,
    S_MUL, S_SNR, S_DECIDE, S_SCORE_DIV, S_SCORE_FIN, S_EMA1, S_EMA2, S_FINISH
  } state_e;

  state_e                     state_q, state_d;
  logic [aevd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       div_last, log_last;

  assign div_last = (cnt_q == aevd_pkg::CNT_W'(aevd_pkg::DIV_STEPS - 1));
  assign log_last = (cnt_q == aevd_pkg::CNT_W'(aevd_pkg::LOG_STEPS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_d = '0;
        if (status_i.restart_op) begin
          cmd_o.restart = 1'b1;
          state_d = S_FINISH;
        end else if (!status_i.calibrated) begin
          cmd_o.cal_acc = 1'b1;
          state_d = S_CAL_INIT;
        end else begin
          cmd_o.log_init_rms = 1'b1;
          state_d = S_LOG_R;
        end
      end
      S_CAL_INIT: begin
        cmd_o.div_init_cal = 1'b1;
        state_d = S_CAL_DIV;
      end
      S_CAL_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          state_d = S_CAL_FIN;
        end
      end
      S_CAL_FIN: begin
        cmd_o.cal_fin = 1'b1;
        state_d = S_FINISH;
      end
      S_LOG_R: begin
        cmd_o.log_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (log_last) begin
          state_d = S_LOG_SAVE;
        end
      end
      S_LOG_SAVE: begin
        cmd_o.log_save = 1'b1;
        cmd_o.log_init_floor = 1'b1;
        cnt_d = '0;
        state_d = S_LOG_F;
      end
      S_LOG_F: begin
        cmd_o.log_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (log_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_SNR;
      end
      S_SNR: begin
        cmd_o.snr = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_d = '0;
        if (status_i.score_en && status_i.range_pos) begin
          cmd_o.div_init_score = 1'b1;
          state_d = S_SCORE_DIV;
        end else if (status_i.score_en) begin
          cmd_o.score_one = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_EMA1;
        end
      end
      S_SCORE_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          state_d = S_SCORE_FIN;
        end
      end
      S_SCORE_FIN: begin
        cmd_o.score_fin = 1'b1;
        state_d = status_i.score_zero ? S_EMA1 : S_FINISH;
      end
      S_EMA1: begin
        cmd_o.ema1 = 1'b1;
        state_d = S_EMA2;
      end
      S_EMA2: begin
        cmd_o.ema2 = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: design/aevd_dp.sv
// datapath: config registers, floor state, shared divider, log unit, result register
// depends on aevd_pkg
module aevd_dp #(
  parameter int unsigned MAX_CAL_FRAMES = aevd_pkg::MAX_CAL_FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aevd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aevd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            opcode_i,
  input  logic [15:0]                     level_rms_i,
  input  aevd_pkg::cmd_t                  cmd_i,
  output aevd_pkg::status_t               status_o,
  output logic [16:0]                     voice_score_o,
  output logic signed [15:0]              snr_db_o,
  output logic [15:0]                     noise_floor_o,
  output logic                            calibrating_o
);

  localparam int unsigned FW = $clog2(MAX_CAL_FRAMES + 1);
  localparam int unsigned DVW = (FW > 17) ? FW : 17;

  function automatic logic [15:0] clamp_fl(logic [31:0] x, logic [15:0] lo, logic [15:0] hi);
    logic [31:0] v;
    v = x;
    if (v > {16'd0, hi}) v = {16'd0, hi};
    if (v < {16'd0, lo}) v = {16'd0, lo};
    return v[15:0];
  endfunction

  logic [16:0] cal_frames_q, alpha_q;
  logic [15:0] init_floor_q, min_floor_q, max_floor_q, min_speech_q;
  logic [14:0] onset_q, sat_q;

  logic          calibrated_q;
  logic [FW-1:0] frames_q;
  logic [31:0]   sum_q;
  logic [15:0]   floor_q;

  logic        op_q;
  logic [15:0] rms_q;
  logic [16:0] score_q;
  logic [15:0] snr_q;
  logic        cal_q;

  logic [DVW:0]   rem_q;
  logic [31:0]    quo_q;
  logic [DVW-1:0] dvs_q;

  logic [30:0] m_q;
  logic [23:0] frac_q;
  logic [3:0]  n_q;
  logic [27:0] lr_q;
  logic signed [56:0] p_q;
  logic [32:0] p1_q;

  logic [16:0]        res_score_q;
  logic signed [15:0] res_snr_q;
  logic [15:0]        res_floor_q;
  logic               res_cal_q;

  // calibration accumulate
  logic [32:0]    sum_add;
  logic [31:0]    sum_new;
  logic [FW-1:0]  frames_new;
  always_comb begin
    sum_add = {1'b0, sum_q} + {17'd0, rms_q};
    sum_new = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
    frames_new = (frames_q < FW'(MAX_CAL_FRAMES)) ? frames_q + 1'b1 : frames_q;
  end

  // divider step
  logic [DVW:0] rem_t;
  logic         rem_ge;
  assign rem_t = {rem_q[DVW-1:0], quo_q[31]};
  assign rem_ge = (rem_t >= {1'b0, dvs_q});

  // log unit
  logic [15:0] log_x;
  logic [3:0]  log_n;
  logic [61:0] sq;
  logic [31:0] sq_s;
  always_comb begin
    log_x = cmd_i.log_init_floor ?
            ((floor_q > min_floor_q) ? floor_q : min_floor_q) :
            ((rms_q > min_floor_q) ? rms_q : min_floor_q);
    if (log_x == 16'd0) log_x = 16'd1;
    log_n = '0;
    for (int i = 1; i < 16; i++) begin
      if (log_x[i]) log_n = 4'(i);
    end
  end
  assign sq = {31'd0, m_q} * {31'd0, m_q};
  assign sq_s = sq[61:30];

  // snr rounding
  logic signed [28:0] log_d;
  logic [56:0]        mag;
  logic [56:0]        mag_r;
  logic [15:0]        snr_new;
  always_comb begin
    log_d = $signed({1'b0, lr_q}) - $signed({1'b0, n_q, frac_q});
    mag = p_q[56] ? 57'(-p_q) : 57'(p_q);
    mag_r = (mag + (57'd1 << 39)) >> 40;
    snr_new = p_q[56] ? 16'(-mag_r[15:0]) : mag_r[15:0];
  end

  // score
  logic [14:0] range_v;
  logic [15:0] num_v;
  logic [16:0] quo_clamp;
  assign range_v = sat_q - onset_q;
  assign num_v = snr_q - {1'b0, onset_q};
  assign quo_clamp = (quo_q > {15'd0, aevd_pkg::ONE_Q16}) ? aevd_pkg::ONE_Q16 : quo_q[16:0];

  // moving average
  logic [16:0] alpha_c, one_m_a;
  logic [15:0] b_c;
  logic [33:0] acc;
  always_comb begin
    alpha_c = (alpha_q > aevd_pkg::ONE_Q16) ? aevd_pkg::ONE_Q16 : alpha_q;
    one_m_a = aevd_pkg::ONE_Q16 - alpha_c;
    b_c = clamp_fl({16'd0, rms_q}, min_floor_q, max_floor_q);
    acc = {1'b0, p1_q} + 34'({17'd0, alpha_c} * {18'd0, b_c}) + 34'd32768;
  end

  always_comb begin
    status_o.restart_op = (op_q == aevd_pkg::OP_RESTART);
    status_o.calibrated = calibrated_q;
    status_o.score_en = (rms_q >= min_speech_q) &&
                        ($signed(snr_q) > $signed({1'b0, onset_q}));
    status_o.range_pos = (sat_q > onset_q);
    status_o.score_zero = (quo_clamp == 17'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_frames_q <= aevd_pkg::RST_CAL_FRAMES;
      init_floor_q <= aevd_pkg::RST_INIT_FLOOR;
      min_floor_q <= aevd_pkg::RST_MIN_FLOOR;
      max_floor_q <= aevd_pkg::RST_MAX_FLOOR;
      alpha_q <= aevd_pkg::RST_ALPHA;
      min_speech_q <= aevd_pkg::RST_MIN_SPEECH;
      onset_q <= aevd_pkg::RST_ONSET;
      sat_q <= aevd_pkg::RST_SAT;
      calibrated_q <= (aevd_pkg::RST_CAL_FRAMES == 17'd0);
      frames_q <= '0;
      sum_q <= '0;
      floor_q <= aevd_pkg::RST_INIT_FLOOR;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aevd_pkg::CFG_CAL_FRAMES: cal_frames_q <= cfg_data_i;
          aevd_pkg::CFG_INIT_FLOOR: init_floor_q <= cfg_data_i[15:0];
          aevd_pkg::CFG_MIN_FLOOR:  min_floor_q <= cfg_data_i[15:0];
          aevd_pkg::CFG_MAX_FLOOR:  max_floor_q <= cfg_data_i[15:0];
          aevd_pkg::CFG_ALPHA:      alpha_q <= cfg_data_i;
          aevd_pkg::CFG_MIN_SPEECH: min_speech_q <= cfg_data_i[15:0];
          aevd_pkg::CFG_ONSET:      onset_q <= cfg_data_i[14:0];
          aevd_pkg::CFG_SAT:        sat_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        calibrated_q <= (cal_frames_q == 17'd0);
        frames_q <= '0;
        sum_q <= '0;
        floor_q <= init_floor_q;
      end
      if (cmd_i.cal_acc) begin
        sum_q <= sum_new;
        frames_q <= frames_new;
      end
      if (cmd_i.cal_fin) begin
        floor_q <= clamp_fl(quo_q, min_floor_q, max_floor_q);
        if (DVW'(frames_q) >= DVW'(cal_frames_q)) calibrated_q <= 1'b1;
      end
      if (cmd_i.ema2) begin
        floor_q <= clamp_fl({14'd0, acc[33:16]}, min_floor_q, max_floor_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      rms_q <= level_rms_i;
      score_q <= '0;
      snr_q <= '0;
      cal_q <= 1'b0;
    end
    if (cmd_i.cal_acc) cal_q <= 1'b1;
    if (cmd_i.div_init_cal) begin
      rem_q <= '0;
      quo_q <= sum_q;
      dvs_q <= DVW'(frames_q);
    end
    if (cmd_i.div_init_score) begin
      rem_q <= '0;
      quo_q <= {num_v, 16'd0} + {18'd0, range_v[14:1]};
      dvs_q <= DVW'(range_v);
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_t - {1'b0, dvs_q} : rem_t;
      quo_q <= {quo_q[30:0], rem_ge};
    end
    if (cmd_i.log_init_rms || cmd_i.log_init_floor) begin
      n_q <= log_n;
      m_q <= {15'd0, log_x} << (5'd30 - {1'b0, log_n});
      frac_q <= '0;
    end
    if (cmd_i.log_step) begin
      m_q <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
      frac_q <= {frac_q[22:0], sq_s[31]};
    end
    if (cmd_i.log_save) lr_q <= {n_q, frac_q};
    if (cmd_i.mul) p_q <= log_d * $signed({1'b0, aevd_pkg::DB_PER_LOG2_Q24});
    if (cmd_i.snr) snr_q <= snr_new;
    if (cmd_i.score_one) score_q <= aevd_pkg::ONE_Q16;
    if (cmd_i.score_fin) score_q <= quo_clamp;
    if (cmd_i.ema1) p1_q <= {16'd0, one_m_a} * {17'd0, floor_q};
    if (cmd_i.out_load) begin
      res_score_q <= score_q;
      res_snr_q <= $signed(snr_q);
      res_floor_q <= floor_q;
      res_cal_q <= cal_q;
    end
  end

  assign voice_score_o = res_score_q;
  assign snr_db_o = res_snr_q;
  assign noise_floor_o = res_floor_q;
  assign calibrating_o = res_cal_q;

endmodule

// File: design/adaptive_energy_voice_detector_top.sv
// top level of the adaptive energy voice detector
// depends on aevd_pkg, aevd_in_if, aevd_out_if, aevd_ctrl, aevd_dp and the macro header
//
// in_i carries one request per audio frame: opcode (0 analyze, 1 restart) and the
// frame rms level. out_o returns exactly one result per request: voice score,
// snr in dB, noise floor and a calibration flag. the user must write registers
// through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle; the
// block itself does not enforce it. one request is worked on at a time; ready is
// high only while the sequencer idles. a restart goes straight to the result
// register; a calibration frame runs the 32-step restoring divider for the running
// mean; an analyzed frame runs two 24-step log2 squaring loops and one snr multiply,
// then pins the score to one, updates the floor, or runs the 32-step divider for
// the score (and updates the floor too when that score comes out zero).
// results sit in an output register: the next request is taken while a result
// waits, and a finished result waits in the sequencer while the receiver stalls.
// reset restores register defaults, clears calibration and sets the floor to its
// initial value; no result is pending after reset.
`include "adaptive_energy_voice_detector_top_macros.svh"
module adaptive_energy_voice_detector_top #(
  parameter int unsigned MAX_CAL_FRAMES = aevd_pkg::MAX_CAL_FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aevd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aevd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  aevd_in_if.sink                         in_i,
  aevd_out_if.source                      out_o
);

  aevd_pkg::cmd_t    cmd;
  aevd_pkg::status_t status;

  aevd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  aevd_dp #(
    .MAX_CAL_FRAMES (MAX_CAL_FRAMES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (in_i.opcode),
    .level_rms_i    (in_i.level_rms),
    .cmd_i          (cmd),
    .status_o       (status),
    .voice_score_o  (out_o.voice_score),
    .snr_db_o       (out_o.snr_db),
    .noise_floor_o  (out_o.noise_floor),
    .calibrating_o  (out_o.calibrating)
  );

  `AEVD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `AEVD_ASSERT_IMP(a_score_range, clk_i, rst_ni, out_o.valid, out_o.voice_score <= 17'd65536)
  `AEVD_ASSERT_IMP(a_cal_quiet, clk_i, rst_ni, out_o.valid && out_o.calibrating,
                   out_o.voice_score == 17'd0 && out_o.snr_db == 16'sd0)

endmodule
